// ===== design/otb_pkg.sv =====
// Shared types and constants for the Otsu threshold binariser.
package otb_pkg;

  // Request and result payloads
  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] result_value;
    logic       overflow;
  } out_rsp_t;

  localparam logic ACT_HISTOGRAM  = 1'b0;
  localparam logic ACT_BINARIZE   = 1'b1;
  localparam logic KIND_THRESHOLD = 1'b0;
  localparam logic KIND_PIXEL     = 1'b1;

  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  // Classified work passed from front to back
  typedef enum logic [1:0] {
    OP_ACC,
    OP_ACC_LAST,
    OP_BIN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] pixel;   // already saturated to the top bin for histogram work
  } q_entry_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = 2;

  // Shared limb multiplier: up to 4 x 2 limbs of 32 bits
  localparam int unsigned LIMB   = 32;
  localparam int unsigned MUL_AW = 128;
  localparam int unsigned MUL_BW = 64;
  localparam int unsigned MUL_PW = 192;

  typedef struct packed {
    logic              start;
    logic [2:0]        na;
    logic [1:0]        nb;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    BS_RUN,
    BS_DRAIN,
    BS_FETCH,
    BS_ACC,
    BS_CHECK,
    BS_ISSUE,
    BS_MUL,
    BS_NEXT,
    BS_REPORT
  } back_state_e;

  typedef enum logic [2:0] {
    MOP_A,     // ST * P
    MOP_B,     // S * N
    MOP_DEN,   // P * (N - P)
    MOP_SQ,    // D * D
    MOP_L,     // D^2 * best denominator
    MOP_R      // best D^2 * denominator
  } mop_e;

endpackage

// ===== design/otsu_threshold_binarizer.sv =====
// Top level of the Otsu global threshold binariser.
//
// Input channel (in_valid_i / in_ready_o / in_req_i): each request is one
// pixel. action 0 counts the pixel into the histogram; with last set it
// also closes the pass and starts the threshold search. action 1 binarises
// the pixel against the current threshold.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): a binarised pixel
// (0 or 255) per binarise request, and one threshold report, with the
// overflow flag, per closed histogram pass.
// Throughput: one histogram or binarise request per cycle, except while the
// search runs or a stalled receiver holds back a binarise request; the
// histogram read-modify-write is a two-stage pipeline with forwarding.
// A binarised pixel passes through the work queue and then the result
// register. The search walks the bins through the histogram RAM port and,
// per bin with a valid split, runs six products on the shared 32x32 limb
// multiplier; requests queue (4 deep) meanwhile.
// Pixels past MAX_PIXELS in one pass are dropped and flagged.
// Reset: histogram empty (per-bin valid bits), count and threshold zero.
// A stalled receiver holds the result register; the queue keeps taking
// requests until it fills, then in_ready_o drops.
module otsu_threshold_binarizer #(
  parameter int unsigned MAX_PIXELS = 1048576,
  parameter int unsigned LEVELS     = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  otb_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output otb_pkg::out_rsp_t out_rsp_o
);
  import otb_pkg::*;

  logic     q_full, q_empty, push, pop;
  q_entry_t entry, head;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  otb_front #(.LEVELS(LEVELS)) u_front (
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (entry)
  );

  otb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // shared multiplier used by the threshold search
  otb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  otb_back #(.MAX_PIXELS(MAX_PIXELS), .LEVELS(LEVELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== design/otb_front.sv =====
// Front end: accepts requests and classifies them for the work queue.
module otb_front #(
  parameter int unsigned LEVELS = 256
) (
  input  logic             in_valid_i,
  input  otb_pkg::in_req_t in_req_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output otb_pkg::q_entry_t entry_o
);
  import otb_pkg::*;

  localparam logic [7:0] TOP_BIN = 8'(LEVELS - 1);

  logic above;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign above      = ({1'b0, in_req_i.pixel} >= 9'(LEVELS));

  always_comb begin
    if (in_req_i.action == ACT_BINARIZE) begin
      entry_o.op    = OP_BIN;
      entry_o.pixel = in_req_i.pixel;
    end else begin
      entry_o.op    = in_req_i.last ? OP_ACC_LAST : OP_ACC;
      entry_o.pixel = above ? TOP_BIN : in_req_i.pixel;
    end
  end

endmodule

// ===== design/otb_queue.sv =====
// Short work queue between the front and back ends.
module otb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  otb_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output otb_pkg::q_entry_t head_o
);
  import otb_pkg::*;

  q_entry_t       mem_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

// ===== design/otb_mul.sv =====
// Limb-serial multiplier: one 32x32 partial product per cycle.
module otb_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  otb_pkg::mul_req_t req_i,
  output otb_pkg::mul_rsp_t rsp_o
);
  import otb_pkg::*;

  logic [MUL_AW-1:0] a_q;
  logic [MUL_BW-1:0] b_q;
  logic [2:0]        na_q;
  logic [1:0]        nb_q;
  logic [1:0]        i_q;
  logic              j_q;
  logic              busy_q, ppv_q, pplast_q, done_q;
  logic [2*LIMB-1:0] pp_q, pp_d;
  logic [2:0]        sh_q;
  logic [MUL_PW-1:0] acc_q;
  logic              last_pp, last_j;

  assign last_j  = ({1'b0, j_q} == nb_q - 2'd1);
  assign last_pp = ({1'b0, i_q} == na_q - 3'd1) && last_j;
  assign pp_d    = (2*LIMB)'(a_q[{i_q, 5'd0} +: LIMB]) * (2*LIMB)'(b_q[{j_q, 5'd0} +: LIMB]);

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ppv_q    <= 1'b0;
      pplast_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last_pp) begin
        busy_q <= 1'b0;
      end
      ppv_q    <= busy_q;
      pplast_q <= busy_q && last_pp;
      done_q   <= ppv_q && pplast_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      na_q  <= req_i.na;
      nb_q  <= req_i.nb;
      i_q   <= '0;
      j_q   <= 1'b0;
      acc_q <= '0;
    end else begin
      if (busy_q) begin
        if (last_j) begin
          j_q <= 1'b0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= 1'b1;
        end
      end
      if (ppv_q) acc_q <= acc_q + ({128'd0, pp_q} << {sh_q, 5'd0});
    end
    pp_q <= pp_d;
    sh_q <= {1'b0, i_q} + {2'b00, j_q};
  end

endmodule

// ===== design/otb_back.sv =====
// Back end: histogram update pipeline, threshold search sequencer and result register.
module otb_back #(
  parameter int unsigned MAX_PIXELS = 1048576,
  parameter int unsigned LEVELS     = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  otb_pkg::q_entry_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output otb_pkg::mul_req_t mul_req_o,
  input  otb_pkg::mul_rsp_t mul_rsp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output otb_pkg::out_rsp_t out_rsp_o
);
  import otb_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned BW   = $clog2(LEVELS);
  localparam int unsigned SW   = BW + CW;
  localparam int unsigned PW   = SW + CW;
  localparam int unsigned DNW  = 2 * CW;
  localparam int unsigned QW   = 2 * PW;
  localparam int unsigned LW   = QW + DNW;
  localparam int unsigned NL_S = (SW + LIMB - 1) / LIMB;
  localparam int unsigned NL_C = (CW + LIMB - 1) / LIMB;
  localparam int unsigned NL_P = (PW + LIMB - 1) / LIMB;
  localparam int unsigned NL_Q = (QW + LIMB - 1) / LIMB;
  localparam int unsigned NL_D = (DNW + LIMB - 1) / LIMB;

  localparam logic [CW-1:0] MAXC   = CW'(MAX_PIXELS);
  localparam logic [BW-1:0] LAST_K = BW'(LEVELS - 2);

  back_state_e state_q, state_d;
  mop_e        op_q;

  // histogram store
  logic [CW-1:0]     hist_mem [LEVELS];
  logic [LEVELS-1:0] vld_q;
  logic [CW-1:0]     rdata_q;
  logic              rvld_q;
  logic [BW-1:0]     raddr;

  logic          upd_vld_q, fwd_vld_q;
  logic [BW-1:0] upd_bin_q, fwd_bin_q;
  logic [CW-1:0] fwd_val_q, upd_old, upd_new;

  logic [CW-1:0] cnt_q;
  logic [SW-1:0] st_q;
  logic          ovf_q;
  logic [7:0]    thr_q;

  // search datapath
  logic [BW-1:0]  k_q, bk_q;
  logic [CW-1:0]  p_q, h;
  logic [SW-1:0]  s_q;
  logic [PW-1:0]  a_q, d_q, b_prod;
  logic [DNW-1:0] den_q, bden_q;
  logic [QW-1:0]  sq_q, bsq_q;
  logic [LW-1:0]  lhs_q;

  logic     out_vld_q, out_free, out_load;
  out_rsp_t out_q, out_data;
  logic     head_acc, cnt_room;

  assign head_acc = (head_i.op != OP_BIN);
  assign cnt_room = (cnt_q < MAXC);
  assign out_free = !out_vld_q || out_ready_i;
  assign h        = rvld_q ? rdata_q : '0;
  assign b_prod   = mul_rsp_i.prod[PW-1:0];

  assign upd_old = (fwd_vld_q && fwd_bin_q == upd_bin_q) ? fwd_val_q : h;
  assign upd_new = upd_old + 1'b1;

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_RUN:    if (pop_o && head_i.op == OP_ACC_LAST) state_d = BS_DRAIN;
      BS_DRAIN:  state_d = BS_FETCH;
      BS_FETCH:  state_d = BS_ACC;
      BS_ACC:    state_d = (k_q == '0) ? BS_FETCH : BS_CHECK;
      BS_CHECK:  state_d = (p_q == '0 || p_q == cnt_q) ? BS_NEXT : BS_ISSUE;
      BS_ISSUE:  state_d = BS_MUL;
      BS_MUL: begin
        if (mul_rsp_i.done) state_d = (op_q == MOP_R) ? BS_NEXT : BS_ISSUE;
      end
      BS_NEXT:   state_d = (k_q == LAST_K) ? BS_REPORT : BS_FETCH;
      BS_REPORT: if (out_free) state_d = BS_RUN;
      default:   state_d = BS_RUN;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    raddr     = head_i.pixel[BW-1:0];
    out_load  = 1'b0;
    out_data  = '{result_kind: KIND_PIXEL, result_value: PIX_BLACK, overflow: 1'b0};
    mul_req_o = '0;
    case (state_q)
      BS_RUN: begin
        if (!empty_i) begin
          if (head_acc) begin
            pop_o = 1'b1;
          end else if (out_free) begin
            pop_o    = 1'b1;
            out_load = 1'b1;
            out_data.result_value = (head_i.pixel >= thr_q) ? PIX_WHITE : PIX_BLACK;
          end
        end
      end
      BS_FETCH: raddr = k_q;
      BS_ISSUE: begin
        mul_req_o.start = 1'b1;
        case (op_q)
          MOP_A: begin
            mul_req_o.a = MUL_AW'(st_q); mul_req_o.b = MUL_BW'(p_q);
            mul_req_o.na = 3'(NL_S); mul_req_o.nb = 2'(NL_C);
          end
          MOP_B: begin
            mul_req_o.a = MUL_AW'(s_q); mul_req_o.b = MUL_BW'(cnt_q);
            mul_req_o.na = 3'(NL_S); mul_req_o.nb = 2'(NL_C);
          end
          MOP_DEN: begin
            mul_req_o.a = MUL_AW'(p_q); mul_req_o.b = MUL_BW'(cnt_q - p_q);
            mul_req_o.na = 3'(NL_C); mul_req_o.nb = 2'(NL_C);
          end
          MOP_SQ: begin
            mul_req_o.a = MUL_AW'(d_q); mul_req_o.b = MUL_BW'(d_q);
            mul_req_o.na = 3'(NL_P); mul_req_o.nb = 2'(NL_P);
          end
          MOP_L: begin
            mul_req_o.a = MUL_AW'(sq_q); mul_req_o.b = MUL_BW'(bden_q);
            mul_req_o.na = 3'(NL_Q); mul_req_o.nb = 2'(NL_D);
          end
          MOP_R: begin
            mul_req_o.a = MUL_AW'(bsq_q); mul_req_o.b = MUL_BW'(den_q);
            mul_req_o.na = 3'(NL_Q); mul_req_o.nb = 2'(NL_D);
          end
          default: mul_req_o.start = 1'b0;
        endcase
      end
      BS_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_data = '{result_kind: KIND_THRESHOLD, result_value: 8'(bk_q),
                       overflow: ovf_q};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_RUN;
      op_q      <= MOP_A;
      vld_q     <= '0;
      upd_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
      cnt_q     <= '0;
      st_q      <= '0;
      ovf_q     <= 1'b0;
      thr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      upd_vld_q <= pop_o && head_acc && cnt_room;
      fwd_vld_q <= upd_vld_q;
      if (upd_vld_q) vld_q[upd_bin_q] <= 1'b1;

      if (pop_o && head_acc) begin
        if (cnt_room) begin
          cnt_q <= cnt_q + 1'b1;
          st_q  <= st_q + SW'(head_i.pixel[BW-1:0]);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      if (state_q == BS_CHECK) op_q <= MOP_A;
      if (state_q == BS_MUL && mul_rsp_i.done) begin
        case (op_q)
          MOP_A:   op_q <= MOP_B;
          MOP_B:   op_q <= MOP_DEN;
          MOP_DEN: op_q <= MOP_SQ;
          MOP_SQ:  op_q <= MOP_L;
          MOP_L:   op_q <= MOP_R;
          default: op_q <= MOP_A;
        endcase
      end

      if (state_q == BS_REPORT && out_free) begin
        thr_q <= 8'(bk_q);
        vld_q <= '0;
        cnt_q <= '0;
        st_q  <= '0;
        ovf_q <= 1'b0;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // histogram memory, registered read
  always_ff @(posedge clk_i) begin
    if (upd_vld_q) hist_mem[upd_bin_q] <= upd_new;
    rdata_q <= hist_mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rvld_q    <= vld_q[raddr];
    upd_bin_q <= head_i.pixel[BW-1:0];
    fwd_bin_q <= upd_bin_q;
    fwd_val_q <= upd_new;
    if (out_load) out_q <= out_data;

    case (state_q)
      BS_DRAIN: begin
        k_q    <= '0;
        bk_q   <= '0;
        bsq_q  <= '0;
        bden_q <= DNW'(1);
      end
      BS_ACC: begin
        if (k_q == '0) begin
          p_q <= h;
          s_q <= '0;
          k_q <= BW'(1);
        end else begin
          p_q <= p_q + h;
          s_q <= s_q + SW'(k_q) * SW'(h);
        end
      end
      BS_NEXT: k_q <= k_q + 1'b1;
      BS_MUL: begin
        if (mul_rsp_i.done) begin
          case (op_q)
            MOP_A:   a_q   <= b_prod;
            MOP_B:   d_q   <= (a_q >= b_prod) ? (a_q - b_prod) : (b_prod - a_q);
            MOP_DEN: den_q <= mul_rsp_i.prod[DNW-1:0];
            MOP_SQ:  sq_q  <= mul_rsp_i.prod[QW-1:0];
            MOP_L:   lhs_q <= mul_rsp_i.prod[LW-1:0];
            MOP_R: begin
              if (lhs_q > mul_rsp_i.prod[LW-1:0]) begin
                bsq_q  <= sq_q;
                bden_q <= den_q;
                bk_q   <= k_q;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/otb_checker.sv =====
// Port-level checks for the Otsu threshold binariser, bound to the top level.
module otb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input otb_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input otb_pkg::out_rsp_t out_rsp_o
);
  import otb_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_pix_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.result_kind == KIND_PIXEL |->
      out_rsp_o.result_value == PIX_BLACK || out_rsp_o.result_value == PIX_WHITE)
    else $error("binarised pixel not 0 or 255");

  a_pix_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.result_kind == KIND_PIXEL |-> !out_rsp_o.overflow)
    else $error("overflow flagged on a pixel result");

  a_thr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.result_kind == KIND_THRESHOLD |->
      out_rsp_o.result_value != PIX_WHITE)
    else $error("threshold beyond search range");

endmodule

bind otsu_threshold_binarizer otb_checker u_otb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
